@@ rtl/core/led2w_pkg.sv @@
// ----------------------------------------------------------------------------
// led2w_pkg
// Shared types and constants for the two-wire LED digit display transmitter.
// ----------------------------------------------------------------------------
package led2w_pkg;

    localparam int MAX_DIGITS_DEF = 6;

    localparam int FUNC_W  = 2;
    localparam int INDEX_W = 3;
    localparam int BYTE_W  = 8;
    localparam int BRIGHT_W = 3;
    localparam int DIGITS_W = 3;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 3;
    localparam int BITCNT_W = 4;

    localparam logic [BYTE_W-1:0]   CMD_DATA = 8'h40;
    localparam logic [BYTE_W-1:0]   CMD_ADDR = 8'hC0;
    localparam logic [BYTE_W-1:0]   CMD_CTRL = 8'h88;
    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_UPDATE = 2'd1,
        FUNC_TICK   = 2'd2
    } func_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BRIGHTNESS    = 1'd0,
        REG_DIGITS_IN_USE = 1'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STAGE_IDLE = 2'd0,
        STAGE_CMD  = 2'd1,
        STAGE_DATA = 2'd2,
        STAGE_CTRL = 2'd3
    } stage_t;

    // One tick per phase; pins listed are the levels after that phase.
    typedef enum logic [3:0] {
        PH_START_HIGH     = 4'd0,
        PH_START_DAT_LOW  = 4'd1,
        PH_BIT_CLK_LOW    = 4'd2,
        PH_BIT_DATA       = 4'd3,
        PH_BIT_CLK_HIGH   = 4'd4,
        PH_STOP_CLK_LOW   = 4'd5,
        PH_STOP_DAT_LOW   = 4'd6,
        PH_STOP_CLK_HIGH  = 4'd7,
        PH_STOP_DAT_HIGH  = 4'd8
    } phase_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] digit_index;
        logic [BYTE_W-1:0]  digit_value;
    } item_t;

    typedef struct packed {
        logic busy_res;
        logic data_pin;
        logic clock_pin;
    } res_t;

    typedef struct packed {
        stage_t             stage;
        logic [BYTE_W-1:0]  first_byte;
        logic [INDEX_W-1:0] digit;
    } frame_t;

endpackage

@@ rtl/core/led2w_frame_sel.sv @@
// ----------------------------------------------------------------------------
// led2w_frame_sel
// Picks the next frame: the first dirty digit at or after the start digit
// and below the scan limit, else the display control frame.
// ----------------------------------------------------------------------------
module led2w_frame_sel
    import led2w_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic [MAX_DIGITS-1:0] dirty,
    input  logic [INDEX_W-1:0]    start_digit,
    input  logic [DIGITS_W-1:0]   limit,
    input  logic [BRIGHT_W-1:0]   brightness,
    output frame_t                frame
);

    logic               found;
    logic [INDEX_W-1:0] hit_digit;

    always_comb begin
        found     = 1'b0;
        hit_digit = start_digit;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (!found && dirty[i] && (3'(i) >= start_digit) && (3'(i) < limit)) begin
                found     = 1'b1;
                hit_digit = 3'(i);
            end
        end
    end

    always_comb begin
        frame.digit = hit_digit;
        if (found) begin
            frame.stage      = STAGE_DATA;
            frame.first_byte = CMD_ADDR | {5'd0, hit_digit};
        end else begin
            frame.stage      = STAGE_CTRL;
            frame.first_byte = CMD_CTRL | {5'd0, brightness};
        end
    end

endmodule

@@ rtl/core/led2w_engine.sv @@
// ----------------------------------------------------------------------------
// led2w_engine
// Digit store, dirty marks, configuration and the frame/phase sequencer.
// Computes the next state and the pin result for one request per cycle while step is high.
// ----------------------------------------------------------------------------
module led2w_engine
    import led2w_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  step,
    input  item_t                 item,
    output res_t                  result
);

    stage_t                stage_reg, stage_next;
    phase_t                phase_reg, phase_next;
    logic [BITCNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic                  second_byte_reg, second_byte_next;
    logic [INDEX_W-1:0]    cur_digit_reg, cur_digit_next;
    logic [BYTE_W-1:0]     shift_reg, shift_next;
    logic                  clk_reg, clk_next;
    logic                  dat_reg, dat_next;
    logic [MAX_DIGITS-1:0] dirty_reg, dirty_next;
    logic [BYTE_W-1:0]     store_reg [MAX_DIGITS];
    logic [BRIGHT_W-1:0]   brightness_reg;
    logic [DIGITS_W-1:0]   digits_reg;

    logic                  idx_ok;
    logic                  store_we;
    logic [DIGITS_W-1:0]   limit;
    logic [INDEX_W-1:0]    sel_start;
    logic [BYTE_W-1:0]     cur_byte;
    frame_t                frame;

    assign idx_ok   = item.digit_index < 3'(MAX_DIGITS);
    assign store_we = step && (item.func == FUNC_WRITE) && idx_ok;
    assign limit    = (digits_reg > 3'(MAX_DIGITS)) ? 3'(MAX_DIGITS) : digits_reg;
    assign sel_start = (stage_reg == STAGE_DATA) ? cur_digit_reg + 3'd1 : cur_digit_reg;

    // Segment byte of the digit being sent; out-of-range reads entry zero.
    always_comb begin
        cur_byte = store_reg[0];
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (cur_digit_reg == 3'(i)) begin
                cur_byte = store_reg[i];
            end
        end
    end

    led2w_frame_sel #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_frame_sel (
        .dirty       (dirty_reg),
        .start_digit (sel_start),
        .limit       (limit),
        .brightness  (brightness_reg),
        .frame       (frame)
    );

    // Next-state logic
    always_comb begin
        stage_next       = stage_reg;
        phase_next       = phase_reg;
        bit_cnt_next     = bit_cnt_reg;
        second_byte_next = second_byte_reg;
        cur_digit_next   = cur_digit_reg;
        shift_next       = shift_reg;
        clk_next         = clk_reg;
        dat_next         = dat_reg;
        dirty_next       = dirty_reg;

        if (step) begin
            case (item.func)
                FUNC_WRITE: begin
                    if (idx_ok) begin
                        dirty_next = dirty_reg | (MAX_DIGITS'(1) << item.digit_index);
                    end
                end
                FUNC_UPDATE: begin
                    if (stage_reg == STAGE_IDLE) begin
                        stage_next       = STAGE_CMD;
                        shift_next       = CMD_DATA;
                        phase_next       = PH_START_HIGH;
                        bit_cnt_next     = '0;
                        second_byte_next = 1'b0;
                        cur_digit_next   = '0;
                    end
                end
                FUNC_TICK: begin
                    if (stage_reg != STAGE_IDLE) begin
                        case (phase_reg)
                            PH_START_HIGH: begin
                                clk_next   = 1'b1;
                                dat_next   = 1'b1;
                                phase_next = PH_START_DAT_LOW;
                            end
                            PH_START_DAT_LOW: begin
                                dat_next     = 1'b0;
                                bit_cnt_next = '0;
                                phase_next   = PH_BIT_CLK_LOW;
                            end
                            PH_BIT_CLK_LOW: begin
                                clk_next   = 1'b0;
                                phase_next = PH_BIT_DATA;
                            end
                            PH_BIT_DATA: begin
                                // Once all data bits are sent, data is released for the acknowledge clock.
                                if (bit_cnt_reg < BITS_PER_BYTE) begin
                                    dat_next = shift_reg[bit_cnt_reg[2:0]];
                                end else begin
                                    dat_next = 1'b1;
                                end
                                phase_next = PH_BIT_CLK_HIGH;
                            end
                            PH_BIT_CLK_HIGH: begin
                                clk_next = 1'b1;
                                if (bit_cnt_reg < BITS_PER_BYTE) begin
                                    bit_cnt_next = bit_cnt_reg + 4'd1;
                                    phase_next   = PH_BIT_CLK_LOW;
                                end else if (stage_reg == STAGE_DATA && !second_byte_reg) begin
                                    second_byte_next = 1'b1;
                                    shift_next       = cur_byte;
                                    bit_cnt_next     = '0;
                                    phase_next       = PH_BIT_CLK_LOW;
                                end else begin
                                    phase_next = PH_STOP_CLK_LOW;
                                end
                            end
                            PH_STOP_CLK_LOW: begin
                                clk_next   = 1'b0;
                                phase_next = PH_STOP_DAT_LOW;
                            end
                            PH_STOP_DAT_LOW: begin
                                dat_next   = 1'b0;
                                phase_next = PH_STOP_CLK_HIGH;
                            end
                            PH_STOP_CLK_HIGH: begin
                                clk_next   = 1'b1;
                                phase_next = PH_STOP_DAT_HIGH;
                            end
                            PH_STOP_DAT_HIGH: begin
                                dat_next         = 1'b1;
                                phase_next       = PH_START_HIGH;
                                bit_cnt_next     = '0;
                                second_byte_next = 1'b0;
                                if (stage_reg == STAGE_CTRL) begin
                                    stage_next     = STAGE_IDLE;
                                    dirty_next     = '0;
                                    cur_digit_next = '0;
                                end else begin
                                    // Advance to the next dirty digit or the control frame
                                    stage_next     = frame.stage;
                                    shift_next     = frame.first_byte;
                                    cur_digit_next = frame.digit;
                                end
                            end
                            default: begin
                                phase_next = PH_START_HIGH;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result of this request: pins and busy after the update
    always_comb begin
        result.clock_pin = clk_next;
        result.data_pin  = dat_next;
        result.busy_res  = (stage_next != STAGE_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg       <= STAGE_IDLE;
            phase_reg       <= PH_START_HIGH;
            bit_cnt_reg     <= '0;
            second_byte_reg <= 1'b0;
            cur_digit_reg   <= '0;
            shift_reg       <= '0;
            clk_reg         <= 1'b1;
            dat_reg         <= 1'b1;
            dirty_reg       <= '0;
        end else begin
            stage_reg       <= stage_next;
            phase_reg       <= phase_next;
            bit_cnt_reg     <= bit_cnt_next;
            second_byte_reg <= second_byte_next;
            cur_digit_reg   <= cur_digit_next;
            shift_reg       <= shift_next;
            clk_reg         <= clk_next;
            dat_reg         <= dat_next;
            dirty_reg       <= dirty_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                store_reg[i] <= '0;
            end
        end else if (store_we) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                if (item.digit_index == 3'(i)) begin
                    store_reg[i] <= item.digit_value;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= 3'd7;
            digits_reg     <= 3'd4;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_addr))
                REG_BRIGHTNESS:    brightness_reg <= cfg_wdata;
                REG_DIGITS_IN_USE: digits_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

endmodule

@@ rtl/core/led_digit_two_wire_transmitter.sv @@
// ----------------------------------------------------------------------------
// led_digit_two_wire_transmitter
// Bit-banged serial writer for a two-wire LED digit display.
// ----------------------------------------------------------------------------
// Each request on the s_ channel gives exactly one result on the m_ channel:
// the clock and data pin levels and the busy flag after that request. The
// block takes one request per cycle while no result stalls it; a request
// lands in an input register, the sequencer updates its state and forms the
// result, and the result sits in an output register. Only a result held by
// m_tready low stalls the input. Write requests store a segment byte and
// mark the digit dirty; an update request while idle arms a transaction
// that each following tick request plays out by one pin phase (start,
// LSB-first bytes each with an acknowledge clock, stop).
// Configuration writes take effect at once.
// ----------------------------------------------------------------------------
module led_digit_two_wire_transmitter
    import led2w_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // digit_index[2:0], digit_value[10:3]
    input  logic [FUNC_W-1:0]     s_tuser,   // func[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata    // clock_pin[0], data_pin[1], busy_res[2]
);

    logic  in_valid_reg;
    item_t in_item_reg;
    logic  out_valid_reg;
    res_t  out_res_reg;
    logic  advance;
    res_t  result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.func        <= s_tuser;
            in_item_reg.digit_index <= s_tdata[2:0];
            in_item_reg.digit_value <= s_tdata[10:3];
        end
    end

    led2w_engine #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .item      (in_item_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_res_reg.busy_res, out_res_reg.data_pin, out_res_reg.clock_pin};

    // Idle bus always rests with both lines high.
    a_idle_pins_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[2]) |-> (m_tdata[0] && m_tdata[1]))
        else $error("idle result with a pin driven low");

    // Input stalls only behind a stalled result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // A request that moves into processing yields a result next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed request produced no result");

endmodule
